// ===== sv/assert_macros.svh =====
// Assertion helper macros for the depth-weighted window blur block.
// Included by files that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DWWB_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define DWWB_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/dwwb_pkg.sv =====
// Shared types and constants of the depth-weighted window blur block.
// Used by the controller, the datapath, the divider and the top level.
package dwwb_pkg;

    localparam int DEPTH_W   = 16;
    localparam int SHADE_W   = 16;
    localparam int GAIN_W    = 8;
    localparam int FALLOFF_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;
    localparam int SUM_W     = 40;
    localparam int TOTAL_W   = 24;
    localparam int WEIGHT_W  = 17;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 48;

    // Shared divider: quotient bits, numerator and divisor widths.
    localparam int QUOT_W = 17;
    localparam int NUM_W  = 48;
    localparam int DEN_W  = 47;
    localparam int CNT_W  = 5;

    localparam logic [GAIN_W-1:0]    SHARPNESS_RESET = 8'd25;
    localparam logic [FALLOFF_W-1:0] FALLOFF_RESET   = 16'd1311;

    localparam logic [1:0] CHAN_LAST = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHARPNESS = 1'b0,
        REG_FALLOFF   = 1'b1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_GAIN,
        S_SQ,
        S_PEN,
        S_RECIP,
        S_WEIGHT,
        S_PROD,
        S_ACC,
        S_AVG_START,
        S_AVG_WAIT,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic       capture;
        logic       diff;
        logic       gain;
        logic       square;
        logic       pen;
        logic       pval;
        logic       weight;
        logic       prod;
        logic       acc;
        logic       avg_start;
        logic       avg_store;
        logic [1:0] chan;
        logic       push;
    } t_cmd;

    typedef struct packed {
        logic                last;
        logic                div_done;
        logic                div_busy;
        logic                div_ovf;
        logic                out_free;
        logic [WEIGHT_W-1:0] weight;
    } t_sts;

endpackage

// ===== sv/depth_weighted_window_blur_core.sv =====
// Depth-weighted window blur: averages the shades of a window of elements,
// each weighted by how close its depth lies to the center depth.
// Input beats carry one element; the beat with tlast set closes the window.
// Configuration channel: index 0 is the sharpness gain (data bits 7:0),
// index 1 is the falloff coefficient (Q0.16); write only while the block is idle.
// Each element is worked through before the next beat can be taken; the
// shared 17-step divider forms its reciprocal along the way.
// On a tlast beat the block then runs three averaging divisions on the same
// divider and then loads the result into the output register.
// The output register holds the result beat while the receiver stalls; the
// block keeps accepting elements of the next window meanwhile and only waits
// if a further result is ready before the held one is taken.
// Reset clears the running sums and restores the default configuration.
// Depends on dwwb_pkg, dwwb_ctrl, dwwb_datapath and assert_macros.svh.
`include "assert_macros.svh"

module depth_weighted_window_blur_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dwwb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dwwb_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    // Element stream.
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // center_depth, sample_depth, shade_red, shade_green, shade_blue (low bits first)
    input  logic [dwwb_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // last_element
    input  logic                                i_s_axis_tlast,
    // Result stream.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // blurred_red, blurred_green, blurred_blue (low bits first)
    output logic [dwwb_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata
);

    dwwb_pkg::t_cmd cmd;
    dwwb_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    dwwb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dwwb_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_s_axis_tdata),
        .i_in_last   (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    // A new element may only enter while the shared divider is free.
    `DWWB_ASSERT_IMP(a_accept_div_idle, i_s_axis_tvalid && o_s_axis_tready, !sts.div_busy)
    // The reciprocal of an element never exceeds the quotient width.
    `DWWB_ASSERT_IMP(a_recip_no_ovf, cmd.weight, !sts.div_ovf)
    // An element weight never exceeds 1.0 in Q1.16.
    `DWWB_ASSERT_IMP(a_weight_range, cmd.prod, sts.weight <= 17'd65536)
    // Handing over a result always shows a valid beat next cycle.
    `DWWB_ASSERT_NXT(a_push_valid, cmd.push, o_m_axis_tvalid)

endmodule

// ===== sv/dwwb_div.sv =====
// Shared restoring divider, one quotient bit per cycle, with an overflow flag.
// Depends on dwwb_pkg for its widths.
module dwwb_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [dwwb_pkg::NUM_W-1:0]   i_num,
    input  logic [dwwb_pkg::DEN_W-1:0]   i_den,
    output logic                         o_busy,
    output logic                         o_done,
    output logic                         o_ovf,
    output logic [dwwb_pkg::QUOT_W-1:0]  o_quot
);

    localparam int DSH_W = dwwb_pkg::DEN_W + dwwb_pkg::QUOT_W - 1;
    localparam int OVF_W = dwwb_pkg::DEN_W + dwwb_pkg::QUOT_W;

    logic                         r_busy;
    logic                         r_done;
    logic                         r_ovf;
    logic [dwwb_pkg::CNT_W-1:0]   r_cnt;
    logic [dwwb_pkg::NUM_W-1:0]   r_rem;
    logic [DSH_W-1:0]             r_dsh;
    logic [dwwb_pkg::QUOT_W-1:0]  r_quot;
    logic                         fits;

    assign fits = {{(DSH_W-dwwb_pkg::NUM_W){1'b0}}, r_rem} >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= dwwb_pkg::CNT_W'(dwwb_pkg::QUOT_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= {i_den, {(dwwb_pkg::QUOT_W-1){1'b0}}};
            r_quot <= '0;
            // Quotient would not fit in the result width.
            r_ovf  <= {{(OVF_W-dwwb_pkg::NUM_W){1'b0}}, i_num}
                      >= {i_den, {dwwb_pkg::QUOT_W{1'b0}}};
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_dsh[dwwb_pkg::NUM_W-1:0];
            end
            r_quot <= {r_quot[dwwb_pkg::QUOT_W-2:0], fits};
            r_dsh  <= r_dsh >> 1;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_ovf  = r_ovf;
    assign o_quot = r_quot;

endmodule

// ===== sv/dwwb_datapath.sv =====
// Datapath of the blur block: config registers, weight arithmetic, running sums,
// final averages and the output register. Depends on dwwb_pkg and dwwb_div.
module dwwb_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic [dwwb_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [dwwb_pkg::CFG_DAT_W-1:0]        i_cfg_data,
    input  logic [dwwb_pkg::IN_DATA_W-1:0]        i_in_data,
    input  logic                                  i_in_last,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic [dwwb_pkg::OUT_DATA_W-1:0]       o_out_data,
    input  dwwb_pkg::t_cmd                        i_cmd,
    output dwwb_pkg::t_sts                        o_sts
);

    logic [dwwb_pkg::GAIN_W-1:0]    r_gain;
    logic [dwwb_pkg::FALLOFF_W-1:0] r_falloff;

    logic [dwwb_pkg::DEPTH_W-1:0]        r_center;
    logic [dwwb_pkg::DEPTH_W-1:0]        r_sample;
    logic signed [dwwb_pkg::SHADE_W-1:0] r_shade [3];
    logic                                r_last;

    logic [31:0] r_dc;
    logic [30:0] r_a16;
    logic [45:0] r_sq;
    logic [38:0] r_pp_lo;
    logic [38:0] r_pp_hi;
    logic [45:0] r_p;
    logic [dwwb_pkg::WEIGHT_W-1:0] r_w;
    logic signed [33:0] r_prod [3];
    logic [dwwb_pkg::SUM_W-1:0]   r_sum [3];
    logic [dwwb_pkg::TOTAL_W-1:0] r_total;
    logic [dwwb_pkg::SHADE_W-1:0] r_avg [3];
    logic                               r_out_valid;
    logic [dwwb_pkg::OUT_DATA_W-1:0]    r_out_data;

    logic [15:0] diff;
    logic [39:0] m;
    logic [40:0] m_rnd;
    logic [32:0] a_full;
    logic [61:0] a_sq;
    logic [62:0] sq_rnd;
    logic [46:0] den_w;
    logic [47:0] num_w;
    logic [62:0] p_full;
    logic [dwwb_pkg::WEIGHT_W-1:0] w_next;

    logic [dwwb_pkg::SUM_W-1:0] sum_sel;
    logic                       neg;
    logic [dwwb_pkg::SUM_W-1:0] mag;
    logic [47:0]                avg_num;
    logic [16:0]                qq;
    logic [dwwb_pkg::SHADE_W-1:0] avg_val;

    logic                               div_start;
    logic [dwwb_pkg::NUM_W-1:0]         div_num;
    logic [dwwb_pkg::DEN_W-1:0]         div_den;
    logic                               div_busy;
    logic                               div_done;
    logic                               div_ovf;
    logic [dwwb_pkg::QUOT_W-1:0]        div_quot;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= dwwb_pkg::SHARPNESS_RESET;
            r_falloff <= dwwb_pkg::FALLOFF_RESET;
        end else if (i_cfg_valid) begin
            case (dwwb_pkg::t_cfg_reg'(i_cfg_index))
                dwwb_pkg::REG_SHARPNESS: r_gain    <= i_cfg_data[dwwb_pkg::GAIN_W-1:0];
                dwwb_pkg::REG_FALLOFF:   r_falloff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Attenuation a = |c - s| * c * gain, rounded to Q.16 and saturated to 31 bits.
    assign diff   = (r_center >= r_sample) ? (r_center - r_sample) : (r_sample - r_center);
    assign m      = {8'b0, r_dc} * {32'b0, r_gain};
    assign m_rnd  = {1'b0, m} + 41'd128;
    assign a_full = m_rnd[40:8];
    assign a_sq   = {31'b0, r_a16} * {31'b0, r_a16};
    assign sq_rnd = {1'b0, a_sq} + 63'd32768;

    // Reciprocal operands: (2^32 + den/2) / den with den = sq + 1.0.
    assign den_w  = {1'b0, r_sq} + 47'd65536;
    assign num_w  = 48'h0001_0000_0000 + {2'b0, den_w[46:1]};

    // Penalty from two registered partial products of falloff * sq.
    assign p_full = {1'b0, r_pp_hi, 23'b0} + {24'b0, r_pp_lo} + 63'd32768;

    assign w_next = ({29'b0, div_quot} > r_p) ? (div_quot - r_p[16:0]) : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_center <= i_in_data[15:0];
            r_sample <= i_in_data[31:16];
            r_shade[0] <= i_in_data[47:32];
            r_shade[1] <= i_in_data[63:48];
            r_shade[2] <= i_in_data[79:64];
            r_last   <= i_in_last;
        end
        if (i_cmd.diff) begin
            r_dc <= {16'b0, diff} * {16'b0, r_center};
        end
        if (i_cmd.gain) begin
            r_a16 <= (a_full > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : a_full[30:0];
        end
        if (i_cmd.square) begin
            r_sq <= sq_rnd[61:16];
        end
        if (i_cmd.pen) begin
            r_pp_lo <= {23'b0, r_falloff} * {16'b0, r_sq[22:0]};
            r_pp_hi <= {23'b0, r_falloff} * {16'b0, r_sq[45:23]};
        end
        if (i_cmd.pval) begin
            r_p <= p_full[61:16];
        end
        if (i_cmd.weight) begin
            r_w <= w_next;
        end
        if (i_cmd.prod) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= 34'(r_shade[c]) * 34'($signed({1'b0, r_w}));
            end
        end
    end

    // Running sums; cleared once the result has been handed to the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= '0;
            end
            r_total <= '0;
        end else if (i_cmd.push) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= '0;
            end
            r_total <= '0;
        end else if (i_cmd.acc) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= r_sum[c] + {{6{r_prod[c][33]}}, r_prod[c]};
            end
            r_total <= r_total + {7'b0, r_w};
        end
    end

    // Final average of one channel, rounded half away from zero.
    assign sum_sel = r_sum[i_cmd.chan];
    assign neg     = sum_sel[dwwb_pkg::SUM_W-1];
    assign mag     = neg ? (40'd0 - sum_sel) : sum_sel;
    assign avg_num = {8'b0, mag} + {25'b0, r_total[23:1]};

    always_comb begin
        qq      = '0;
        avg_val = '0;
        if (r_total == '0) begin
            avg_val = '0;
        end else if (neg) begin
            qq      = (div_ovf || (div_quot > 17'd32768)) ? 17'd32768 : div_quot;
            avg_val = 16'(17'h1_0000 - qq);
        end else begin
            avg_val = (div_ovf || (div_quot > 17'd32767)) ? 16'h7FFF : div_quot[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.avg_store) begin
            r_avg[i_cmd.chan] <= avg_val;
        end
    end

    assign div_start = i_cmd.pen | i_cmd.avg_start;
    assign div_num   = i_cmd.avg_start ? avg_num : num_w;
    assign div_den   = i_cmd.avg_start ? {23'b0, r_total} : den_w;

    dwwb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_ovf   (div_ovf),
        .o_quot  (div_quot)
    );

    // Output register: holds one result beat until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_data <= {r_avg[2], r_avg[1], r_avg[0]};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_sts.last     = r_last;
    assign o_sts.div_done = div_done;
    assign o_sts.div_busy = div_busy;
    assign o_sts.div_ovf  = div_ovf;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.weight   = r_w;

endmodule

// ===== sv/dwwb_ctrl.sv =====
// Controller of the blur block: sequences one element through the datapath and
// runs the three final divisions at the end of a window. Depends on dwwb_pkg.
module dwwb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  dwwb_pkg::t_sts  i_sts,
    output dwwb_pkg::t_cmd  o_cmd
);

    dwwb_pkg::t_state r_state;
    dwwb_pkg::t_state n_state;
    logic [1:0]       r_chan;
    logic [1:0]       n_chan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dwwb_pkg::S_IDLE;
            r_chan  <= '0;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_chan     = r_chan;
        o_cmd      = '0;
        o_cmd.chan = r_chan;
        o_in_ready = 1'b0;
        case (r_state)
            dwwb_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = dwwb_pkg::S_DIFF;
                end
            end
            dwwb_pkg::S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = dwwb_pkg::S_GAIN;
            end
            dwwb_pkg::S_GAIN: begin
                o_cmd.gain = 1'b1;
                n_state    = dwwb_pkg::S_SQ;
            end
            dwwb_pkg::S_SQ: begin
                o_cmd.square = 1'b1;
                n_state      = dwwb_pkg::S_PEN;
            end
            dwwb_pkg::S_PEN: begin
                o_cmd.pen = 1'b1;
                n_state   = dwwb_pkg::S_RECIP;
            end
            dwwb_pkg::S_RECIP: begin
                o_cmd.pval = 1'b1;
                if (i_sts.div_done) begin
                    n_state = dwwb_pkg::S_WEIGHT;
                end
            end
            dwwb_pkg::S_WEIGHT: begin
                o_cmd.weight = 1'b1;
                n_state      = dwwb_pkg::S_PROD;
            end
            dwwb_pkg::S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = dwwb_pkg::S_ACC;
            end
            dwwb_pkg::S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_sts.last) begin
                    n_chan  = '0;
                    n_state = dwwb_pkg::S_AVG_START;
                end else begin
                    n_state = dwwb_pkg::S_IDLE;
                end
            end
            dwwb_pkg::S_AVG_START: begin
                o_cmd.avg_start = 1'b1;
                n_state         = dwwb_pkg::S_AVG_WAIT;
            end
            dwwb_pkg::S_AVG_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.avg_store = 1'b1;
                    if (r_chan == dwwb_pkg::CHAN_LAST) begin
                        n_state = dwwb_pkg::S_PUSH;
                    end else begin
                        n_chan  = r_chan + 1'b1;
                        n_state = dwwb_pkg::S_AVG_START;
                    end
                end
            end
            dwwb_pkg::S_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = dwwb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dwwb_pkg::S_IDLE;
            end
        endcase
    end

endmodule
